// ===== hw/rtl/cdp_pkg.sv =====
// ----------------------------------------------------------------------------
// cdp_pkg
// shared types and constants for the checked decimal int64 parser
// ----------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

	// parse phases; codes above error are treated as error
	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_SIGN  = 3'd1,
		PH_DIGIT = 3'd2,
		PH_TRAIL = 3'd3,
		PH_ERR   = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [63:0] mag;
	} parse_state_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
	} parse_result_t;

	localparam logic [63:0] MagLimit = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MagTenth = 64'd922337203685477580;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChVt    = 8'h0b;
	localparam logic [7:0] ChFf    = 8'h0c;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	localparam logic [3:0] MaxLastDigit = 4'd8;

endpackage

`default_nettype wire

// ===== hw/rtl/cdp_step.sv =====
// ----------------------------------------------------------------------------
// cdp_step
// next parse state and terminator result for one character
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_step (
	input  wire logic [7:0]            character,
	input  wire cdp_pkg::parse_state_t cur,
	output cdp_pkg::parse_state_t      nxt,
	output cdp_pkg::parse_result_t     res
);

	logic        is_space;
	logic        is_digit;
	logic        is_sign;
	logic [3:0]  digit;
	logic        add_ok;
	logic [63:0] mag_add;
	logic        accepted;

	assign is_space = (character == cdp_pkg::ChSpace) || (character == cdp_pkg::ChTab)
		|| (character == cdp_pkg::ChLf) || (character == cdp_pkg::ChCr)
		|| (character == cdp_pkg::ChFf) || (character == cdp_pkg::ChVt);
	assign is_digit = (character >= cdp_pkg::ChZero) && (character <= cdp_pkg::ChNine);
	assign is_sign  = (character == cdp_pkg::ChPlus) || (character == cdp_pkg::ChMinus);
	// '0'..'9' carry the digit in the low nibble
	assign digit    = character[3:0];

	// overflow past 2^63 check before the times-ten update
	assign add_ok  = !(cur.mag > cdp_pkg::MagTenth)
		&& !((cur.mag == cdp_pkg::MagTenth) && (digit > cdp_pkg::MaxLastDigit));
	assign mag_add = (cur.mag << 3) + (cur.mag << 1) + {60'd0, digit};

	assign accepted = ((cur.phase == cdp_pkg::PH_DIGIT) || (cur.phase == cdp_pkg::PH_TRAIL))
		&& (cur.neg || (cur.mag != cdp_pkg::MagLimit));

	always_comb begin
		res.ok    = accepted;
		res.value = accepted ? (cur.neg ? (64'd0 - cur.mag) : cur.mag) : 64'd0;
		nxt = cur;
		if (character == cdp_pkg::ChNul) begin
			nxt.phase = cdp_pkg::PH_LEAD;
			nxt.neg   = 1'b0;
			nxt.mag   = 64'd0;
		end else begin
			unique case (cur.phase)
				cdp_pkg::PH_LEAD: begin
					if (is_space) begin
						nxt.phase = cdp_pkg::PH_LEAD;
					end else if (is_sign) begin
						nxt.neg   = (character == cdp_pkg::ChMinus);
						nxt.phase = cdp_pkg::PH_SIGN;
					end else if (is_digit && add_ok) begin
						nxt.mag   = mag_add;
						nxt.phase = cdp_pkg::PH_DIGIT;
					end else begin
						nxt.phase = cdp_pkg::PH_ERR;
					end
				end
				cdp_pkg::PH_SIGN: begin
					if (is_digit && add_ok) begin
						nxt.mag   = mag_add;
						nxt.phase = cdp_pkg::PH_DIGIT;
					end else begin
						nxt.phase = cdp_pkg::PH_ERR;
					end
				end
				cdp_pkg::PH_DIGIT: begin
					if (is_digit && add_ok) begin
						nxt.mag = mag_add;
					end else if (is_space) begin
						nxt.phase = cdp_pkg::PH_TRAIL;
					end else begin
						nxt.phase = cdp_pkg::PH_ERR;
					end
				end
				cdp_pkg::PH_TRAIL: begin
					if (!is_space) begin
						nxt.phase = cdp_pkg::PH_ERR;
					end
				end
				default: begin
					nxt.phase = cdp_pkg::PH_ERR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/checked_decimal_int64_parser.sv =====
// ----------------------------------------------------------------------------
// checked_decimal_int64_parser
// streaming decimal string to signed 64-bit integer with overflow checking
// ----------------------------------------------------------------------------
//
// channel   handshake                    payload
// -------   --------------------------   ---------------------------
// char      char_valid / char_ready      character[7:0]
// result    result_valid / result_ready  parsed_ok, parsed_value[63:0]
//
// one character beat is accepted every cycle while no zero byte waits; the update is a times-ten
// plus digit add and a few compares between the input register and the
// parse state / result registers
// a zero byte passes from the input register into the result register, which drives its result beat
// arst_n clears the input register valid, the parse state and the result valid
// a zero byte waits in the input register only while a result beat is held
// and not taken; other characters never wait on the result side
`default_nettype none

module checked_decimal_int64_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               char_valid,
	output logic                    char_ready,
	input  wire logic [7:0]         character,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic                    parsed_ok,
	output logic signed [63:0]      parsed_value
);

	// input register
	logic                   valid_s1;
	logic [7:0]             char_s1;

	// parse state
	cdp_pkg::parse_state_t  state_q;
	cdp_pkg::parse_state_t  state_nxt;
	cdp_pkg::parse_result_t res;

	// result register
	logic                   res_valid_q;
	logic                   res_ok_q;
	logic [63:0]            res_value_q;

	logic                   term_s1;
	logic                   adv_s1;

	assign term_s1 = (char_s1 == cdp_pkg::ChNul);
	// only a terminator needs room in the result register
	assign adv_s1     = valid_s1 && (!term_s1 || !res_valid_q || result_ready);
	assign char_ready = !valid_s1 || adv_s1;

	cdp_step u_step (
		.character (char_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= character;
		end
	end

	// parse state, back to leading whitespace after each terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= cdp_pkg::PH_LEAD;
			state_q.neg   <= 1'b0;
			state_q.mag   <= 64'd0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && term_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && term_s1) begin
			res_ok_q    <= res.ok;
			res_value_q <= res.value;
		end
	end

	assign result_valid = res_valid_q;
	assign parsed_ok    = res_ok_q;
	assign parsed_value = res_value_q;

endmodule

`default_nettype wire

// ===== test/checked_decimal_int64_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_decimal_int64_parser_tb
// self-checking bench for the streaming decimal to int64 parser
// ----------------------------------------------------------------------------
// characters are driven one beat at a time; a scoreboard class tracks the
// parse state of every accepted beat and queues the result each zero byte
// should produce, then compares every result beat field by field
// a directed set of strings covers the range limits, signs, whitespace and
// junk; random strings follow, mostly well formed with random content,
// under several sender / receiver idling mixes and one long receiver hold
// ----------------------------------------------------------------------------

module checked_decimal_int64_parser_tb;

	localparam int CyclePeriod  = 10;
	localparam int ResetCycles  = 10;
	localparam int DrainCycles  = 20;
	localparam int CycleLimit   = 500000;
	localparam int PhaseChars   = 325;
	localparam int HoldCycles   = 400;
	localparam int MaxReports   = 100;

	// ------------------------------------------------------------------------
	// scoreboard: shadow parse state plus queue of pending results
	// ------------------------------------------------------------------------
	class parse_scoreboard;
		cdp_pkg::phase_t        phase;
		bit                     neg;
		bit [63:0]              mag;
		cdp_pkg::parse_result_t pending_q[$];
		int                     errors;

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = cdp_pkg::PH_LEAD;
			neg   = 1'b0;
			mag   = '0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == cdp_pkg::ChSpace || c == cdp_pkg::ChTab || c == cdp_pkg::ChLf ||
				c == cdp_pkg::ChCr || c == cdp_pkg::ChFf || c == cdp_pkg::ChVt;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= cdp_pkg::ChZero && c <= cdp_pkg::ChNine;
		endfunction

		// times-ten plus digit with the 2^63 ceiling; 0 on overflow
		function bit add_digit(logic [7:0] c);
			logic [63:0] d;
			d = 64'(c - cdp_pkg::ChZero);
			if (mag > cdp_pkg::MagTenth)
				return 1'b0;
			if (mag == cdp_pkg::MagTenth && d > 64'(cdp_pkg::MaxLastDigit))
				return 1'b0;
			mag = mag * 64'd10 + d;
			return 1'b1;
		endfunction

		// one accepted character beat
		function void note_char(logic [7:0] c);
			cdp_pkg::parse_result_t r;
			if (c == cdp_pkg::ChNul) begin
				r.ok    = 1'b0;
				r.value = '0;
				if (phase == cdp_pkg::PH_DIGIT || phase == cdp_pkg::PH_TRAIL) begin
					if (neg) begin
						r.ok    = 1'b1;
						r.value = 64'd0 - mag;
					end else if (mag != cdp_pkg::MagLimit) begin
						r.ok    = 1'b1;
						r.value = mag;
					end
				end
				pending_q.push_back(r);
				clear_state();
				return;
			end
			case (phase)
				cdp_pkg::PH_LEAD: begin
					if (is_blank(c)) begin
						phase = cdp_pkg::PH_LEAD;
					end else if (c == cdp_pkg::ChPlus || c == cdp_pkg::ChMinus) begin
						neg   = (c == cdp_pkg::ChMinus);
						phase = cdp_pkg::PH_SIGN;
					end else if (is_digit(c)) begin
						phase = add_digit(c) ? cdp_pkg::PH_DIGIT : cdp_pkg::PH_ERR;
					end else begin
						phase = cdp_pkg::PH_ERR;
					end
				end
				cdp_pkg::PH_SIGN: begin
					if (is_digit(c))
						phase = add_digit(c) ? cdp_pkg::PH_DIGIT : cdp_pkg::PH_ERR;
					else
						phase = cdp_pkg::PH_ERR;
				end
				cdp_pkg::PH_DIGIT: begin
					if (is_digit(c)) begin
						if (!add_digit(c))
							phase = cdp_pkg::PH_ERR;
					end else if (is_blank(c)) begin
						phase = cdp_pkg::PH_TRAIL;
					end else begin
						phase = cdp_pkg::PH_ERR;
					end
				end
				cdp_pkg::PH_TRAIL: begin
					if (!is_blank(c))
						phase = cdp_pkg::PH_ERR;
				end
				default: begin
					phase = cdp_pkg::PH_ERR;
				end
			endcase
		endfunction

		task report(string msg);
			if (errors < MaxReports)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// one accepted result beat against the oldest pending result
		task check_result(logic ok, logic [63:0] value);
			cdp_pkg::parse_result_t r;
			if (pending_q.size() == 0) begin
				report($sformatf("result beat ok=%0b value=%h with nothing pending",
					ok, value));
				return;
			end
			r = pending_q.pop_front();
			if (ok !== r.ok)
				report($sformatf("parsed_ok got %b want %b", ok, r.ok));
			if (value !== r.value)
				report($sformatf("parsed_value got %h want %h", value, r.value));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// signals; the driven ones are known from time zero
	// ------------------------------------------------------------------------
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               char_valid   = 1'b0;
	logic               char_ready;
	logic [7:0]         character    = 8'h00;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               parsed_ok;
	logic signed [63:0] parsed_value;

	parse_scoreboard sb;
	logic [7:0]      line_q[$];        // string being built, no terminator yet
	int              snd_idle_pct  = 0;
	int              rcv_stall_pct = 0;
	int              hold_count    = 0; // receiver hold-off request, in cycles
	int              cycle_count   = 0;

	checked_decimal_int64_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.character    (character),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.parsed_ok    (parsed_ok),
		.parsed_value (parsed_value)
	);

	initial begin
		forever #(CyclePeriod / 2) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off counted down here
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_count > 0) begin
				result_ready <= 1'b0;
				hold_count = hold_count - 1;
			end else begin
				result_ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(parsed_ok, parsed_value);
	end

	// ------------------------------------------------------------------------
	// string building
	// ------------------------------------------------------------------------
	function automatic logic [7:0] pick_blank();
		case ($urandom_range(5))
			0: return cdp_pkg::ChSpace;
			1: return cdp_pkg::ChTab;
			2: return cdp_pkg::ChLf;
			3: return cdp_pkg::ChCr;
			4: return cdp_pkg::ChFf;
			default: return cdp_pkg::ChVt;
		endcase
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic void push_blanks(int n);
		for (int i = 0; i < n; i++)
			line_q.push_back(pick_blank());
	endfunction

	// every whitespace byte once
	function automatic void push_all_blanks();
		line_q.push_back(cdp_pkg::ChSpace);
		line_q.push_back(cdp_pkg::ChTab);
		line_q.push_back(cdp_pkg::ChLf);
		line_q.push_back(cdp_pkg::ChCr);
		line_q.push_back(cdp_pkg::ChFf);
		line_q.push_back(cdp_pkg::ChVt);
	endfunction

	// random string: mostly well formed, some corrupted, some pure noise
	function automatic void make_random_line(bit short_lines);
		int          kind;
		int          n;
		logic [63:0] m;
		kind = $urandom_range(99);
		if (short_lines) begin
			push_text($sformatf("%0d", $urandom_range(99)));
		end else if (kind < 75) begin
			push_blanks($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
			case ($urandom_range(2))
				0: line_q.push_back(cdp_pkg::ChPlus);
				1: line_q.push_back(cdp_pkg::ChMinus);
				default: ;
			endcase
			if ($urandom_range(7) == 0)
				push_blanks(1);
			if ($urandom_range(7) == 0)
				push_text("00");
			case ($urandom_range(9))
				0, 1, 2, 3: m = 64'($urandom_range(999));
				4, 5:       m = {$urandom, $urandom} >> $urandom_range(63);
				6, 7, 8:    m = cdp_pkg::MagLimit - 64'd12 + 64'($urandom_range(24));
				default:    m = {$urandom, $urandom};
			endcase
			push_text($sformatf("%0d", m));
			// an extra digit pushes big values past the range
			if ($urandom_range(9) == 0)
				line_q.push_back(cdp_pkg::ChZero + 8'($urandom_range(9)));
			push_blanks($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
			// corrupt some well-formed strings with one stray byte
			if (kind >= 60) begin
				n = $urandom_range(line_q.size());
				line_q.insert(n, 8'($urandom_range(1, 255)));
			end
		end else if (kind < 85) begin
			n = $urandom_range(4);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(3))
					0: line_q.push_back(cdp_pkg::ChPlus);
					1: line_q.push_back(cdp_pkg::ChMinus);
					default: line_q.push_back(pick_blank());
				endcase
			end
		end else begin
			n = $urandom_range(8);
			for (int i = 0; i < n; i++)
				line_q.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	// ------------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------------

	// one character beat; inputs change on the falling edge
	task send_char(logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		character  <= c;
		do
			@(posedge clk);
		while (!char_ready);
		sb.note_char(c);
	endtask

	// the built string plus its zero terminator
	task send_line();
		line_q.push_back(cdp_pkg::ChNul);
		while (line_q.size() > 0)
			send_char(line_q.pop_front());
	endtask

	task run_phase(int snd_pct, int rcv_pct, bit short_lines);
		int sent;
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		sent = 0;
		while (sent < PhaseChars) begin
			make_random_line(short_lines);
			sent += line_q.size() + 1;
			send_line();
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed strings, no idling
		send_line();                                   // empty
		push_all_blanks();
		send_line();                                   // whitespace only
		push_all_blanks();
		push_text("7");
		push_all_blanks();
		send_line();                                   // every blank both sides
		push_text("+");
		send_line();                                   // lone sign
		push_text("-");
		send_line();
		push_text("0");
		send_line();
		push_text("-0");
		send_line();
		push_text("9223372036854775807");
		send_line();                                   // max positive
		push_text("-9223372036854775808");
		send_line();                                   // min negative
		push_text("9223372036854775808");
		send_line();                                   // 2^63 without minus
		push_text("+9223372036854775808");
		send_line();
		push_text("-9223372036854775809");
		send_line();                                   // last digit overflow
		push_text("92233720368547758070");
		send_line();                                   // overflow past a tenth
		push_text("00000000000000000000000001");
		send_line();                                   // long leading zeros
		push_text("--5");
		send_line();                                   // second sign
		push_text("5 -");
		send_line();                                   // sign after trailing blank
		push_text("12 3");
		send_line();                                   // digit after trailing blank
		push_text("1x");
		send_line();                                   // junk after digits
		line_q.push_back(8'hff);
		push_text("7");
		send_line();                                   // high byte
		line_q.push_back(8'h80);
		send_line();
		push_text("a123");
		send_line();                                   // digits after error
		push_text(" -42  ");
		send_line();

		// random strings under each idling mix
		run_phase(0, 0, 1'b0);
		run_phase(87, 0, 1'b0);
		run_phase(0, 87, 1'b0);
		run_phase(31, 31, 1'b0);
		// long receiver hold while short strings keep coming, so the input stalls
		hold_count = HoldCycles;
		run_phase(0, 0, 1'b1);

		@(negedge clk);
		char_valid <= 1'b0;

		// drain, then keep watching for any stray beat
		while (sb.pending_q.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.pending_q.size() > 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/cdp_pkg.sv
hw/rtl/cdp_step.sv
hw/rtl/checked_decimal_int64_parser.sv
test/checked_decimal_int64_parser_tb.sv
